### design/pdq_pkg.sv
// ----------------------------------------------------------------------------
// pdq_pkg - shared types for the process deque
// Sizes, operation and status codes, FSM states, and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pdq_pkg;

    localparam int DEPTH   = 64;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int PID_W   = 15;
    localparam int PCB_W   = 16;
    localparam int JOB_W   = 16;
    localparam int OCC_W   = 7;

    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_PEEK_FRONT = 3'd4,
        FN_PEEK_BACK  = 3'd5,
        FN_REMOVE     = 3'd6,
        FN_FIND       = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RDWAIT,
        S_SCAN,
        S_MOVE,
        S_FINISH
    } state_t;

    // read address select
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_BACK,
        RD_NEXT1,
        RD_NEXT2
    } rd_sel_t;

    // result register load select
    typedef enum logic [2:0] {
        RES_HOLD,
        RES_FULL,
        RES_EMPTY,
        RES_PUSH,
        RES_READ
    } res_sel_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [PCB_W-1:0] pcb;
        logic [JOB_W-1:0] job;
    } entry_t;

    typedef struct packed {
        logic     load_op;
        rd_sel_t  rd_sel;
        logic     idx_clr;
        logic     idx_inc;
        res_sel_t res_sel;
        logic     move_wr;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  empty;
        logic  full;
        logic  match;
        logic  last_scan;
        logic  last_move;
        logic  out_free;
    } sts_t;

endpackage

### design/pdq_ctrl.sv
// ----------------------------------------------------------------------------
// pdq_ctrl - operation sequencer
// Decodes one item, steps reads, scans and compaction moves, then commits.
// ----------------------------------------------------------------------------
module pdq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pdq_pkg::sts_t sts,
    output pdq_pkg::cmd_t cmd
);

    pdq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.load_op = 1'b0;
        cmd.rd_sel  = pdq_pkg::RD_HEAD;
        cmd.idx_clr = 1'b0;
        cmd.idx_inc = 1'b0;
        cmd.res_sel = pdq_pkg::RES_HOLD;
        cmd.move_wr = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            pdq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_op = 1'b1;
                    state_next  = pdq_pkg::S_DECODE;
                end
            end
            pdq_pkg::S_DECODE: begin
                if ((sts.func inside {pdq_pkg::FN_PUSH_FRONT, pdq_pkg::FN_PUSH_BACK})
                        && sts.full) begin
                    cmd.res_sel = pdq_pkg::RES_FULL;
                    state_next  = pdq_pkg::S_FINISH;
                end else if (!(sts.func inside {pdq_pkg::FN_PUSH_FRONT,
                        pdq_pkg::FN_PUSH_BACK}) && sts.empty) begin
                    cmd.res_sel = pdq_pkg::RES_EMPTY;
                    state_next  = pdq_pkg::S_FINISH;
                end else begin
                    case (sts.func)
                        pdq_pkg::FN_PUSH_FRONT: begin
                            cmd.res_sel = pdq_pkg::RES_PUSH;
                            state_next  = pdq_pkg::S_FINISH;
                        end
                        pdq_pkg::FN_PUSH_BACK: begin
                            if (sts.empty) begin
                                cmd.res_sel = pdq_pkg::RES_PUSH;
                                state_next  = pdq_pkg::S_FINISH;
                            end else begin
                                cmd.rd_sel = pdq_pkg::RD_BACK;
                                state_next = pdq_pkg::S_RDWAIT;
                            end
                        end
                        pdq_pkg::FN_POP_FRONT, pdq_pkg::FN_PEEK_FRONT: begin
                            cmd.rd_sel = pdq_pkg::RD_HEAD;
                            state_next = pdq_pkg::S_RDWAIT;
                        end
                        pdq_pkg::FN_POP_BACK, pdq_pkg::FN_PEEK_BACK: begin
                            cmd.rd_sel = pdq_pkg::RD_BACK;
                            state_next = pdq_pkg::S_RDWAIT;
                        end
                        default: begin
                            // remove and find both start a scan at the front
                            cmd.rd_sel  = pdq_pkg::RD_HEAD;
                            cmd.idx_clr = 1'b1;
                            state_next  = pdq_pkg::S_SCAN;
                        end
                    endcase
                end
            end
            pdq_pkg::S_RDWAIT: begin
                cmd.res_sel = (sts.func == pdq_pkg::FN_PUSH_BACK) ? pdq_pkg::RES_PUSH
                                                                  : pdq_pkg::RES_READ;
                state_next  = pdq_pkg::S_FINISH;
            end
            pdq_pkg::S_SCAN: begin
                cmd.rd_sel = pdq_pkg::RD_NEXT1;
                if (sts.match) begin
                    cmd.res_sel = pdq_pkg::RES_READ;
                    if (sts.func == pdq_pkg::FN_REMOVE && !sts.last_scan) begin
                        state_next = pdq_pkg::S_MOVE;
                    end else begin
                        state_next = pdq_pkg::S_FINISH;
                    end
                end else if (sts.last_scan) begin
                    cmd.res_sel = pdq_pkg::RES_EMPTY;
                    state_next  = pdq_pkg::S_FINISH;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            pdq_pkg::S_MOVE: begin
                cmd.move_wr = 1'b1;
                cmd.rd_sel  = pdq_pkg::RD_NEXT2;
                if (sts.last_move) begin
                    state_next = pdq_pkg::S_FINISH;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            pdq_pkg::S_FINISH: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = pdq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pdq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### design/pdq_datapath.sv
// ----------------------------------------------------------------------------
// pdq_datapath - entry store, pointers and result register
// Circular entry memory with one write and one registered read port, head,
// tail and count, scan index, result capture and the output register.
// ----------------------------------------------------------------------------
module pdq_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [2:0]                s_func,
    input  logic [pdq_pkg::PID_W-1:0] s_key_pid,
    input  logic [pdq_pkg::PCB_W-1:0] s_pcb_ref,
    input  logic [pdq_pkg::JOB_W-1:0] s_job_id,
    input  pdq_pkg::cmd_t             cmd,
    output pdq_pkg::sts_t             sts,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [pdq_pkg::PID_W-1:0] m_out_pid,
    output logic [pdq_pkg::PCB_W-1:0] m_out_ref,
    output logic [pdq_pkg::JOB_W-1:0] m_out_job,
    output logic [pdq_pkg::OCC_W-1:0] m_occupancy
);

    localparam int SLOT_W = pdq_pkg::SLOT_W;
    localparam int CNT_W  = pdq_pkg::CNT_W;
    localparam int SUM_W  = pdq_pkg::SUM_W;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(pdq_pkg::DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(pdq_pkg::DEPTH - 1) : s - 1'b1;
    endfunction

    // slot of the k-th entry from the front
    function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  k);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(k);
        if (s >= SUM_W'(pdq_pkg::DEPTH)) begin
            s = s - SUM_W'(pdq_pkg::DEPTH);
        end
        if (s >= SUM_W'(pdq_pkg::DEPTH)) begin
            s = '0;
        end
        return s[SLOT_W-1:0];
    endfunction

    pdq_pkg::entry_t entry_mem [pdq_pkg::DEPTH];
    pdq_pkg::entry_t rd_entry_reg;

    pdq_pkg::func_t            op_func_reg;
    logic [pdq_pkg::PID_W-1:0] op_pid_reg;
    logic [pdq_pkg::PCB_W-1:0] op_pcb_reg;
    logic [pdq_pkg::JOB_W-1:0] op_job_reg;

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg;

    pdq_pkg::status_t res_status_reg;
    pdq_pkg::entry_t  res_entry_reg;

    logic                      m_valid_reg;
    pdq_pkg::status_t          m_status_reg;
    pdq_pkg::entry_t           m_entry_reg;
    logic [pdq_pkg::OCC_W-1:0] m_occ_reg;

    logic [SUM_W-1:0]          idx_p1, idx_p2;
    logic [SLOT_W-1:0]         rd_addr, wr_addr;
    logic                      wr_en;
    pdq_pkg::entry_t           wr_data;
    logic [pdq_pkg::JOB_W-1:0] push_job;
    logic                      is_push, commit_ok;

    assign idx_p1 = SUM_W'(idx_reg) + SUM_W'(1);
    assign idx_p2 = SUM_W'(idx_reg) + SUM_W'(2);

    assign sts.func      = op_func_reg;
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CNT_W'(pdq_pkg::DEPTH));
    assign sts.match     = (rd_entry_reg.pid == op_pid_reg);
    assign sts.last_scan = (idx_p1 >= SUM_W'(count_reg));
    assign sts.last_move = (idx_p2 >= SUM_W'(count_reg));
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        case (cmd.rd_sel)
            pdq_pkg::RD_HEAD:  rd_addr = head_reg;
            pdq_pkg::RD_BACK:  rd_addr = slot_dec(tail_reg);
            pdq_pkg::RD_NEXT1: rd_addr = slot_at(head_reg, idx_p1[CNT_W-1:0]);
            pdq_pkg::RD_NEXT2: rd_addr = slot_at(head_reg, idx_p2[CNT_W-1:0]);
            default:           rd_addr = head_reg;
        endcase
    end

    assign is_push   = (op_func_reg == pdq_pkg::FN_PUSH_FRONT) ||
                       (op_func_reg == pdq_pkg::FN_PUSH_BACK);
    assign commit_ok = cmd.commit && (res_status_reg == pdq_pkg::STAT_OK);

    // move one entry forward during compaction, or store a pushed entry
    always_comb begin
        wr_en = cmd.move_wr || (commit_ok && is_push);
        if (cmd.move_wr) begin
            wr_addr = slot_at(head_reg, idx_reg);
            wr_data = rd_entry_reg;
        end else begin
            wr_addr = (op_func_reg == pdq_pkg::FN_PUSH_FRONT) ? slot_dec(head_reg)
                                                              : tail_reg;
            wr_data = res_entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_entry_reg <= entry_mem[rd_addr];
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_op) begin
            op_func_reg <= pdq_pkg::func_t'(s_func);
            op_pid_reg  <= s_key_pid;
            op_pcb_reg  <= s_pcb_ref;
            op_job_reg  <= s_job_id;
        end
    end

    always_comb begin
        if (op_func_reg == pdq_pkg::FN_PUSH_FRONT) begin
            push_job = op_job_reg;
        end else if (count_reg == '0) begin
            push_job = pdq_pkg::JOB_W'(1);
        end else if (rd_entry_reg.job == '1) begin
            push_job = '1;
        end else begin
            push_job = rd_entry_reg.job + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.res_sel)
            pdq_pkg::RES_FULL: begin
                res_status_reg <= pdq_pkg::STAT_FULL;
                res_entry_reg  <= '0;
            end
            pdq_pkg::RES_EMPTY: begin
                res_status_reg <= pdq_pkg::STAT_EMPTY;
                res_entry_reg  <= '0;
            end
            pdq_pkg::RES_PUSH: begin
                res_status_reg    <= pdq_pkg::STAT_OK;
                res_entry_reg.pid <= op_pid_reg;
                res_entry_reg.pcb <= op_pcb_reg;
                res_entry_reg.job <= push_job;
            end
            pdq_pkg::RES_READ: begin
                res_status_reg <= pdq_pkg::STAT_OK;
                res_entry_reg  <= rd_entry_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (commit_ok) begin
            case (op_func_reg)
                pdq_pkg::FN_PUSH_FRONT: begin
                    head_next  = slot_dec(head_reg);
                    count_next = count_reg + 1'b1;
                end
                pdq_pkg::FN_PUSH_BACK: begin
                    tail_next  = slot_inc(tail_reg);
                    count_next = count_reg + 1'b1;
                end
                pdq_pkg::FN_POP_FRONT: begin
                    head_next  = slot_inc(head_reg);
                    count_next = count_reg - 1'b1;
                end
                pdq_pkg::FN_POP_BACK, pdq_pkg::FN_REMOVE: begin
                    tail_next  = slot_dec(tail_reg);
                    count_next = count_reg - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status_reg <= res_status_reg;
            m_entry_reg  <= res_entry_reg;
            m_occ_reg    <= pdq_pkg::OCC_W'(count_next);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_pid   = m_entry_reg.pid;
    assign m_out_ref   = m_entry_reg.pcb;
    assign m_out_job   = m_entry_reg.job;
    assign m_occupancy = m_occ_reg;

endmodule

### design/process_deque_with_key_removal.sv
// ----------------------------------------------------------------------------
// process_deque_with_key_removal - bounded deque of process entries
// Push, pop and peek at either end, plus find and remove by process id.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per operation (s_func, s_key_pid, s_pcb_ref,
//   s_job_id). s_ready is high only while no operation is in flight.
//   Result channel m_*: exactly one item per input item, in order, held in
//   an output register until m_ready takes it.
// Sequence, from accept to m_valid:
//   push front, push back to empty, full or empty refusal: decode, then commit.
//   push back, pop, peek: decode, one read of the entry store, then commit.
//   find: a scan from the front that ends at the match or after the last entry.
//   remove: scan as for find, plus one compaction move per entry behind the match.
//   The longest operations are set by the single read port of the
//   entry store, which is walked one entry a cycle for scan and compaction.
//   The next item is accepted in the cycle after the result is registered.
// Reset: aresetn (synchronous, active low) empties the deque; the entry
//   store itself is not cleared, only head, tail, count and m_valid.
// Stall: a result held by a low m_ready blocks only the commit of the
//   following operation; that operation is accepted and worked meanwhile.
// ----------------------------------------------------------------------------
module process_deque_with_key_removal (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_func,
    input  logic [pdq_pkg::PID_W-1:0] s_key_pid,
    input  logic [pdq_pkg::PCB_W-1:0] s_pcb_ref,
    input  logic [pdq_pkg::JOB_W-1:0] s_job_id,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [pdq_pkg::PID_W-1:0] m_out_pid,
    output logic [pdq_pkg::PCB_W-1:0] m_out_ref,
    output logic [pdq_pkg::JOB_W-1:0] m_out_job,
    output logic [pdq_pkg::OCC_W-1:0] m_occupancy
);

    // command and status bundles between sequencer and datapath
    pdq_pkg::cmd_t cmd;
    pdq_pkg::sts_t sts;

    // sequence each item: decode, read or scan, compact, commit
    pdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // hold entries, pointers and the result register
    pdq_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_func      (s_func),
        .s_key_pid   (s_key_pid),
        .s_pcb_ref   (s_pcb_ref),
        .s_job_id    (s_job_id),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_pid   (m_out_pid),
        .m_out_ref   (m_out_ref),
        .m_out_job   (m_out_job),
        .m_occupancy (m_occupancy)
    );

    // one operation in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an operation is in flight");

    // a refused push reports a full deque
    a_full_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == pdq_pkg::STAT_FULL)
            |-> (m_occupancy == pdq_pkg::OCC_W'(pdq_pkg::DEPTH)))
        else $error("full status with occupancy below depth");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
